// ===== hw/rtl/lpm_pkg.sv =====
// shared types and constants for the ipv4 longest prefix match engine
package lpm_pkg;

    localparam int ROUTE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(ROUTE_ENTRIES);
    localparam int CELL_W        = 5;
    localparam int NUM_CELLS     = 1 << CELL_W;
    localparam int ROW_W         = ADDR_W - CELL_W;
    localparam int ROWS          = ROUTE_ENTRIES / NUM_CELLS;

    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 4;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 40;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_REPLY
    } lpm_state_t;

    typedef struct packed {
        logic [IP_W-1:0]   prefix;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
    } lpm_entry_t;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] col;
        lpm_entry_t        entry;
    } lpm_wr_t;

    // running best for one row, carried from cell to cell
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic              found;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
    } lpm_tok_t;

    typedef struct packed {
        logic              found;
        logic [IP_W-1:0]   hop;
        logic [PORT_W-1:0] port;
    } lpm_res_t;

endpackage

// ===== hw/rtl/lpm_cell.sv =====
// one cell of the route chain: a slice of the table and one compare stage
module lpm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lpm_pkg::CELL_W-1:0]  cell_id,
    input  logic [lpm_pkg::IP_W-1:0]    lookup_addr,
    input  logic [lpm_pkg::COUNT_W-1:0] limit,
    input  lpm_pkg::lpm_wr_t            wr,
    input  lpm_pkg::lpm_tok_t           tok_in,
    output lpm_pkg::lpm_tok_t           tok_out
);

    lpm_pkg::lpm_entry_t mem [lpm_pkg::ROWS];
    lpm_pkg::lpm_entry_t rd_reg;
    lpm_pkg::lpm_tok_t   tok_a_reg;
    lpm_pkg::lpm_tok_t   tok_out_reg;
    lpm_pkg::lpm_tok_t   tok_next;
    logic [lpm_pkg::COUNT_W-1:0] entry_idx;
    logic                        hit;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.col == cell_id))
        begin
            mem[wr.row] <= wr.entry;
        end
        rd_reg <= mem[tok_in.row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg   <= '0;
            tok_out_reg <= '0;
        end
        else
        begin
            tok_a_reg   <= tok_in;
            tok_out_reg <= tok_next;
        end
    end

    // entry index is row-major: row * cells + cell
    always_comb
    begin
        entry_idx = lpm_pkg::COUNT_W'({tok_a_reg.row, cell_id});
        hit       = (entry_idx < limit) && ((lookup_addr & rd_reg.mask) == rd_reg.prefix);
        tok_next  = tok_a_reg;
        if (tok_a_reg.valid && hit && (!tok_a_reg.found || (rd_reg.mask > tok_a_reg.mask)))
        begin
            tok_next.found = 1'b1;
            tok_next.mask  = rd_reg.mask;
            tok_next.hop   = rd_reg.hop;
            tok_next.port  = rd_reg.port;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

// ===== hw/rtl/lpm_fold.sv =====
// folds the row results leaving the chain into one best route
module lpm_fold (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  lpm_pkg::lpm_tok_t tok_in,
    output lpm_pkg::lpm_res_t result,
    output logic              done
);

    logic                         acc_found_reg;
    logic [lpm_pkg::IP_W-1:0]     acc_mask_reg;
    logic [lpm_pkg::IP_W-1:0]     acc_hop_reg;
    logic [lpm_pkg::PORT_W-1:0]   acc_port_reg;
    logic                         done_reg;
    logic                         take;

    // rows arrive in ascending order, so a strict compare keeps the lowest index
    assign take = tok_in.valid && tok_in.found
                  && (!acc_found_reg || (tok_in.mask > acc_mask_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_found_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= tok_in.valid && tok_in.last;
            if (clear)
            begin
                acc_found_reg <= 1'b0;
            end
            else if (take)
            begin
                acc_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            acc_mask_reg <= tok_in.mask;
            acc_hop_reg  <= tok_in.hop;
            acc_port_reg <= tok_in.port;
        end
    end

    assign result.found = acc_found_reg;
    assign result.hop   = acc_found_reg ? acc_hop_reg : '0;
    assign result.port  = acc_found_reg ? acc_port_reg : '0;
    assign done         = done_reg;

endmodule

// ===== hw/rtl/ipv4_longest_prefix_match_top.sv =====
// top level of the ipv4 longest prefix match route engine
//
//  channel   direction  signals                                   beat carries
//  s_axis    in         tvalid tready tdata[143:0] tuser[0]       route write or lookup
//  m_axis    out        tvalid tready tdata[39:0]  tuser[0]       write ack or lookup reply
//  cfg       in         valid ready data[10:0]                    route_count register
//
//  one item at a time; a write's ack beat is offered in the cycle after its accept
//  a lookup sweeps every row through the 32-cell chain, each cell a memory read and
//  a compare, and the fold then reduces the row results to one best route
//  rst_n clears control state only; the route table holds garbage until written
//  a stalled m_axis holds its beat; s_axis stays not ready until the beat leaves
module ipv4_longest_prefix_match_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // entry_index[9:0] entry_prefix[41:10] entry_mask[73:42]
    // entry_next_hop[105:74] entry_port[109:106] lookup_addr[141:110] zero[143:142]
    input  logic [lpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                     s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // route_found[0] hop_addr[32:1] out_port[36:33] zero[39:37]
    output logic [lpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // is_lookup_reply[0]
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpm_pkg::COUNT_W-1:0]    cfg_data
);

    // input field unpacking
    logic [lpm_pkg::IDX_W-1:0]  in_index;
    logic [lpm_pkg::IP_W-1:0]   in_prefix;
    logic [lpm_pkg::IP_W-1:0]   in_mask;
    logic [lpm_pkg::IP_W-1:0]   in_hop;
    logic [lpm_pkg::PORT_W-1:0] in_port;
    logic [lpm_pkg::IP_W-1:0]   in_addr;

    assign in_index  = s_axis_tdata[9:0];
    assign in_prefix = s_axis_tdata[41:10];
    assign in_mask   = s_axis_tdata[73:42];
    assign in_hop    = s_axis_tdata[105:74];
    assign in_port   = s_axis_tdata[109:106];
    assign in_addr   = s_axis_tdata[141:110];

    lpm_pkg::lpm_state_t state_reg, state_next;

    logic [lpm_pkg::COUNT_W-1:0] route_count_reg;
    logic [lpm_pkg::COUNT_W-1:0] limit;
    logic [lpm_pkg::IP_W-1:0]    addr_reg;
    logic [lpm_pkg::ROW_W-1:0]   row_reg, row_next;

    logic                        out_lookup_reg, out_lookup_next;
    logic                        out_found_reg, out_found_next;
    logic [lpm_pkg::IP_W-1:0]    out_hop_reg, out_hop_next;
    logic [lpm_pkg::PORT_W-1:0]  out_port_reg, out_port_next;

    logic                        in_beat;
    logic                        is_write;
    logic                        fold_clear;
    logic                        fold_done;
    lpm_pkg::lpm_res_t           fold_res;
    lpm_pkg::lpm_wr_t            wr;
    lpm_pkg::lpm_tok_t           sweep_tok;
    lpm_pkg::lpm_tok_t           chain [lpm_pkg::NUM_CELLS+1];

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign is_write = (s_axis_tuser[0] == lpm_pkg::REQ_WRITE);

    // config: always ready; user keeps block idle whenever it is written (unchecked)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            route_count_reg <= cfg_data;
        end
    end

    // counts beyond the table size clamp to the table size
    assign limit = (route_count_reg > lpm_pkg::COUNT_W'(lpm_pkg::ROUTE_ENTRIES))
                   ? lpm_pkg::COUNT_W'(lpm_pkg::ROUTE_ENTRIES) : route_count_reg;

    // route write goes straight to the owning cell on the accept edge
    always_comb
    begin
        wr.en = in_beat && is_write
                && (lpm_pkg::COUNT_W'(in_index) < lpm_pkg::COUNT_W'(lpm_pkg::ROUTE_ENTRIES));
        wr.col          = in_index[lpm_pkg::CELL_W-1:0];
        wr.row          = lpm_pkg::ROW_W'(in_index >> lpm_pkg::CELL_W);
        wr.entry.prefix = in_prefix;
        wr.entry.mask   = in_mask;
        wr.entry.hop    = in_hop;
        wr.entry.port   = in_port;
    end

    // lookup address is held for the whole sweep
    always_ff @(posedge clk)
    begin
        if (in_beat && !is_write)
        begin
            addr_reg <= in_addr;
        end
    end

    // control fsm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lpm_pkg::ST_IDLE;
            row_reg        <= '0;
            out_lookup_reg <= 1'b0;
            out_found_reg  <= 1'b0;
            out_hop_reg    <= '0;
            out_port_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            out_lookup_reg <= out_lookup_next;
            out_found_reg  <= out_found_next;
            out_hop_reg    <= out_hop_next;
            out_port_reg   <= out_port_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        out_lookup_next = out_lookup_reg;
        out_found_next  = out_found_reg;
        out_hop_next    = out_hop_reg;
        out_port_next   = out_port_reg;
        s_axis_tready   = 1'b0;
        m_axis_tvalid   = 1'b0;
        fold_clear      = 1'b0;
        sweep_tok       = '0;
        case (state_reg)
            lpm_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_beat)
                begin
                    if (is_write)
                    begin
                        // write ack carries all zeros
                        out_lookup_next = lpm_pkg::REQ_WRITE;
                        out_found_next  = 1'b0;
                        out_hop_next    = '0;
                        out_port_next   = '0;
                        state_next      = lpm_pkg::ST_REPLY;
                    end
                    else
                    begin
                        fold_clear = 1'b1;
                        row_next   = '0;
                        state_next = lpm_pkg::ST_SWEEP;
                    end
                end
            end
            lpm_pkg::ST_SWEEP:
            begin
                // one row token enters the chain per cycle
                sweep_tok.valid = 1'b1;
                sweep_tok.row   = row_reg;
                sweep_tok.last  = (row_reg == lpm_pkg::ROW_W'(lpm_pkg::ROWS - 1));
                row_next        = row_reg + 1'b1;
                if (sweep_tok.last)
                begin
                    state_next = lpm_pkg::ST_DRAIN;
                end
            end
            lpm_pkg::ST_DRAIN:
            begin
                if (fold_done)
                begin
                    out_lookup_next = lpm_pkg::REQ_LOOKUP;
                    out_found_next  = fold_res.found;
                    out_hop_next    = fold_res.hop;
                    out_port_next   = fold_res.port;
                    state_next      = lpm_pkg::ST_REPLY;
                end
            end
            lpm_pkg::ST_REPLY:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = lpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign chain[0] = sweep_tok;

    // the chain of cells, each owning entries with index mod cells equal to its id
    for (genvar c = 0; c < lpm_pkg::NUM_CELLS; c++)
    begin : g_cell
        lpm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_id     (lpm_pkg::CELL_W'(c)),
            .lookup_addr (addr_reg),
            .limit       (limit),
            .wr          (wr),
            .tok_in      (chain[c]),
            .tok_out     (chain[c+1])
        );
    end

    lpm_fold u_fold (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (fold_clear),
        .tok_in (chain[lpm_pkg::NUM_CELLS]),
        .result (fold_res),
        .done   (fold_done)
    );

    assign m_axis_tuser = out_lookup_reg;
    assign m_axis_tdata = {3'b000, out_port_reg, out_hop_reg, out_found_reg};

endmodule

// ===== hw/rtl/lpm_checker.sv =====
// port-level checks for the route engine, bound to the top level
module lpm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic [0:0]                     s_axis_tuser,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [lpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);

    // reply beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                             && $stable(m_axis_tuser))
        else $error("reply beat changed while stalled");

    // one item at a time: no input beat while a reply is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while reply pending");

    // a write is acknowledged on the next cycle
    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == lpm_pkg::REQ_WRITE)
        |=> m_axis_tvalid && (m_axis_tuser[0] == lpm_pkg::REQ_WRITE))
        else $error("write ack missing");

    // acks and misses carry zero hop and port
    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata == '0))
        else $error("miss or ack with nonzero payload");

    // an ack never reports a route
    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == lpm_pkg::REQ_WRITE) |-> !m_axis_tdata[0])
        else $error("write ack flags a route");

endmodule

bind ipv4_longest_prefix_match_top lpm_checker u_lpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// ===== verif/ipv4_longest_prefix_match_top_tb.sv =====
// testbench for the ipv4 longest prefix match route engine: random route tables and lookups
module ipv4_longest_prefix_match_top_tb;

    localparam int ITEMS_TARGET = 1850;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int END_WAIT     = 120;
    localparam int COUNT_MAX    = (1 << lpm_pkg::COUNT_W) - 1;

    typedef struct packed {
        logic                       req;
        logic [lpm_pkg::IDX_W-1:0]  index;
        logic [lpm_pkg::IP_W-1:0]   prefix;
        logic [lpm_pkg::IP_W-1:0]   mask;
        logic [lpm_pkg::IP_W-1:0]   hop;
        logic [lpm_pkg::PORT_W-1:0] port;
        logic [lpm_pkg::IP_W-1:0]   addr;
    } route_req_t;

    typedef struct packed {
        logic                       is_lookup;
        logic                       found;
        logic [lpm_pkg::IP_W-1:0]   hop;
        logic [lpm_pkg::PORT_W-1:0] port;
    } route_reply_t;

    // mirrors the route table and register, predicts and checks every reply beat
    class route_reply_checker;
        logic [lpm_pkg::IP_W-1:0]    prefix_tab [lpm_pkg::ROUTE_ENTRIES];
        logic [lpm_pkg::IP_W-1:0]    mask_tab   [lpm_pkg::ROUTE_ENTRIES];
        logic [lpm_pkg::IP_W-1:0]    hop_tab    [lpm_pkg::ROUTE_ENTRIES];
        logic [lpm_pkg::PORT_W-1:0]  port_tab   [lpm_pkg::ROUTE_ENTRIES];
        bit                          written    [lpm_pkg::ROUTE_ENTRIES];
        int                          filled;
        logic [lpm_pkg::COUNT_W-1:0] route_count;
        route_reply_t                replies_due [$];
        int                          errors;

        function new();
            foreach (written[i])
                written[i] = 1'b0;
            filled      = 0;
            route_count = '0;
            errors      = 0;
        endfunction

        function route_reply_t predict_lookup(input logic [lpm_pkg::IP_W-1:0] addr);
            route_reply_t             rep;
            logic [lpm_pkg::IP_W-1:0] best_mask;
            int                       lim;
            rep       = '{is_lookup: 1'b1, found: 1'b0, hop: '0, port: '0};
            best_mask = '0;
            lim       = (route_count > lpm_pkg::ROUTE_ENTRIES) ?
                        lpm_pkg::ROUTE_ENTRIES : int'(route_count);
            for (int i = 0; i < lim; i++)
            begin
                // greater mask wins, equal masks keep the lower index
                if ((addr & mask_tab[i]) == prefix_tab[i] &&
                    (!rep.found || mask_tab[i] > best_mask))
                begin
                    rep.found = 1'b1;
                    best_mask = mask_tab[i];
                    rep.hop   = hop_tab[i];
                    rep.port  = port_tab[i];
                end
            end
            return rep;
        endfunction

        function void accept_request(input route_req_t r);
            if (r.req == lpm_pkg::REQ_WRITE)
            begin
                prefix_tab[r.index] = r.prefix;
                mask_tab[r.index]   = r.mask;
                hop_tab[r.index]    = r.hop;
                port_tab[r.index]   = r.port;
                written[r.index]    = 1'b1;
                while (filled < lpm_pkg::ROUTE_ENTRIES && written[filled])
                    filled++;
                replies_due.push_back('{is_lookup: 1'b0, found: 1'b0, hop: '0, port: '0});
            end
            else
                replies_due.push_back(predict_lookup(r.addr));
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_reply(input logic [lpm_pkg::OUT_DATA_W-1:0] data, input logic lookup_flag);
            route_reply_t want;
            if (replies_due.size() == 0)
            begin
                report_mismatch($sformatf("reply beat with none pending, tdata=%h", data));
                return;
            end
            want = replies_due.pop_front();
            if (lookup_flag !== want.is_lookup)
                report_mismatch($sformatf("is_lookup_reply got %b want %b",
                                          lookup_flag, want.is_lookup));
            if (data[0] !== want.found)
                report_mismatch($sformatf("route_found got %b want %b", data[0], want.found));
            if (data[32:1] !== want.hop)
                report_mismatch($sformatf("hop_addr got %h want %h", data[32:1], want.hop));
            if (data[36:33] !== want.port)
                report_mismatch($sformatf("out_port got %h want %h", data[36:33], want.port));
        endtask
    endclass

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic [lpm_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]                      s_axis_tuser  = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [lpm_pkg::COUNT_W-1:0]     cfg_data      = '0;

    route_reply_checker       board;
    logic [lpm_pkg::IP_W-1:0] addr_pool [6];
    int                       tx_quiet;
    int                       rx_quiet;
    int                       items_sent;
    int                       cycles = 0;

    ipv4_longest_prefix_match_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random wait per beat, with occasional stretches of none
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic route_req_t directed_write(input int unsigned idx,
                                                  input logic [lpm_pkg::IP_W-1:0] prefix,
                                                  input logic [lpm_pkg::IP_W-1:0] mask,
                                                  input logic [lpm_pkg::IP_W-1:0] hop,
                                                  input logic [lpm_pkg::PORT_W-1:0] port);
        route_req_t r;
        r.req    = lpm_pkg::REQ_WRITE;
        r.index  = idx[lpm_pkg::IDX_W-1:0];
        r.prefix = prefix;
        r.mask   = mask;
        r.hop    = hop;
        r.port   = port;
        r.addr   = $urandom();
        return r;
    endfunction

    function automatic route_req_t directed_lookup(input logic [lpm_pkg::IP_W-1:0] addr);
        route_req_t r;
        r.req    = lpm_pkg::REQ_LOOKUP;
        r.index  = lpm_pkg::IDX_W'($urandom_range(0, lpm_pkg::ROUTE_ENTRIES - 1));
        r.prefix = $urandom();
        r.mask   = $urandom();
        r.hop    = $urandom();
        r.port   = lpm_pkg::PORT_W'($urandom_range(0, 15));
        r.addr   = addr;
        return r;
    endfunction

    // mostly contiguous masks over a few shared bases so routes nest and overlap
    function automatic route_req_t random_write(input int unsigned idx);
        route_req_t               r;
        logic [lpm_pkg::IP_W-1:0] base;
        int unsigned              len;
        int unsigned              kind;
        r    = directed_lookup($urandom());
        base = ($urandom_range(0, 3) == 0) ? $urandom() : addr_pool[$urandom_range(0, 5)];
        len  = $urandom_range(0, lpm_pkg::IP_W);
        kind = $urandom_range(0, 15);
        r.req   = lpm_pkg::REQ_WRITE;
        r.index = idx[lpm_pkg::IDX_W-1:0];
        r.mask  = {lpm_pkg::IP_W{1'b1}} << (lpm_pkg::IP_W - len);
        if (kind == 0)
            r.mask = $urandom();
        r.prefix = base & r.mask;
        // stray prefix bits below the mask, where any land, make an entry that never matches
        if (kind == 1)
            r.prefix = r.prefix | ($urandom() & ~r.mask);
        return r;
    endfunction

    function automatic route_req_t random_lookup();
        route_req_t               r;
        int                       lim;
        int unsigned              sel;
        int unsigned              i;
        logic [lpm_pkg::IP_W-1:0] m;
        r   = directed_lookup($urandom());
        lim = (board.route_count > lpm_pkg::ROUTE_ENTRIES) ?
              lpm_pkg::ROUTE_ENTRIES : int'(board.route_count);
        sel = $urandom_range(0, 7);
        if (lim > 0 && sel < 5)
        begin
            // aim at an in-use route with random host bits
            i      = $urandom_range(0, lim - 1);
            m      = board.mask_tab[i];
            r.addr = (board.prefix_tab[i] & m) | ($urandom() & ~m);
        end
        else if (sel < 7)
            r.addr = addr_pool[$urandom_range(0, 5)]
                     ^ ($urandom() >> $urandom_range(0, lpm_pkg::IP_W));
        return r;
    endfunction

    function automatic int unsigned pick_index();
        case ($urandom_range(0, 3))
            0:       return (board.filled < lpm_pkg::ROUTE_ENTRIES) ? board.filled : 0;
            1:       return $urandom_range(0, lpm_pkg::ROUTE_ENTRIES - 1);
            default: return (board.filled > 0) ? $urandom_range(0, board.filled - 1) : 0;
        endcase
    endfunction

    // never counts in an entry that has not been written
    function automatic int unsigned pick_count();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return (board.filled > 0) ? 1 : 0;
            4:       return $urandom_range(0, board.filled);
            5:       return (board.filled == lpm_pkg::ROUTE_ENTRIES) ?
                            $urandom_range(lpm_pkg::ROUTE_ENTRIES, COUNT_MAX) : board.filled;
            default: return board.filled;
        endcase
    endfunction

    // valid stays high into the next beat when no gap is drawn
    task automatic send_request(input route_req_t r);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= {2'b00, r.addr, r.port, r.hop, r.mask, r.prefix, r.index};
        do @(posedge clk); while (!s_axis_tready);
        board.accept_request(r);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_route_count(input int unsigned value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value[lpm_pkg::COUNT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.route_count = value[lpm_pkg::COUNT_W-1:0];
    endtask

    task automatic run_phase(input int items, input int write_pct);
        for (int k = 0; k < items; k++)
        begin
            if ($urandom_range(0, 99) < write_pct)
                send_request(random_write(pick_index()));
            else
                send_request(random_lookup());
        end
    endtask

    // result side: random stalls, every beat checked
    initial
    begin : reply_side
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_quiet);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_reply(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    initial
    begin : stimulus
        int n;
        board      = new();
        tx_quiet   = 0;
        rx_quiet   = 0;
        items_sent = 0;
        foreach (addr_pool[i])
            addr_pool[i] = $urandom();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table in use: nothing can match
        set_route_count(0);
        send_request(directed_lookup(32'h0000_0000));
        send_request(directed_lookup(32'hFFFF_FFFF));

        // default route, nested prefixes, a tie, a dead entry and a non-contiguous mask
        send_request(directed_write(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0));
        send_request(directed_write(1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'h1));
        send_request(directed_write(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'h2));
        send_request(directed_write(3, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 4'h3));
        send_request(directed_write(4, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0A01_0203, 4'h4));
        send_request(directed_write(5, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FD, 4'h5));
        send_request(directed_write(6, 32'h0A02_0005, 32'hFFFF_0000, 32'h0A02_00FE, 4'h6));
        send_request(directed_write(7, 32'h0A00_0200, 32'hFF00_FF00, 32'h0A00_02FE, 4'h7));
        send_request(directed_write(lpm_pkg::ROUTE_ENTRIES - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 4'hF));
        // routes written but none counted in
        send_request(directed_lookup(32'h0A01_0203));

        set_route_count(8);
        send_request(directed_lookup(32'h0A01_0203));
        send_request(directed_lookup(32'h0A01_0209));
        send_request(directed_lookup(32'h0A01_0909));
        send_request(directed_lookup(32'h0A09_0909));
        send_request(directed_lookup(32'h0A09_0209));
        send_request(directed_lookup(32'h0A02_0005));
        send_request(directed_lookup(32'hC0A8_0101));
        send_request(directed_lookup(32'hFFFF_FFFF));
        send_request(directed_lookup(32'h0000_0000));

        // only the default route left in use
        set_route_count(1);
        send_request(directed_lookup(32'h0A01_0203));

        // grow the table while changing the count between phases
        while (items_sent < 700)
        begin
            set_route_count(pick_count());
            n = $urandom_range(40, 120);
            run_phase(n, 35);
        end

        // fill every remaining entry so the full table and oversize counts are legal
        wait_drained();
        for (int i = 0; i < lpm_pkg::ROUTE_ENTRIES; i++)
        begin
            if (!board.written[i])
                send_request(random_write(i));
        end

        set_route_count(lpm_pkg::ROUTE_ENTRIES);
        run_phase(60, 15);
        set_route_count(COUNT_MAX);
        run_phase(60, 15);

        while (items_sent < ITEMS_TARGET)
        begin
            set_route_count(pick_count());
            n = $urandom_range(40, 120);
            run_phase(n, 25);
        end

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (board.errors == 0 && board.replies_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_cell.sv
hw/rtl/lpm_fold.sv
hw/rtl/ipv4_longest_prefix_match_top.sv
hw/rtl/lpm_checker.sv
verif/ipv4_longest_prefix_match_top_tb.sv
